@@ rtl/core/lfu_cache_table_assert.svh @@
// Assertion macros shared by the cache table RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled while arst_n is low.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Types, constants and helpers shared by the LFU cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	localparam int Capacity = 16;
	localparam int IdxW     = $clog2(Capacity);
	localparam int OccW     = IdxW + 1;
	localparam int CfgW     = 5;

	localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] lookup_key;
		logic signed [31:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} out_item_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
		logic [31:0] use_count;
		logic [31:0] stamp;
	} entry_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] x);
		sat_inc = (x == CntMax) ? CntMax : x + 32'd1;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lfu_entry_ram.sv @@
// ----------------------------------------------------------------------------
// lfu_entry_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_entry_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [lfu_pkg::IdxW-1:0]  waddr,
	input  wire lfu_pkg::entry_t           wdata,
	input  wire logic                      re,
	input  wire logic [lfu_pkg::IdxW-1:0]  raddr,
	output lfu_pkg::entry_t                rdata
);

	lfu_pkg::entry_t mem_q [lfu_pkg::Capacity];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lfu_cache_table.sv @@
// Sequence: an accepted operation scans all 16 entries through the single read port of the entry
// memory, compares each returned entry, closes the scan and, in the update state, writes back and
// loads the output register; the update stalls while a result not yet taken is still held.
// A new operation is accepted only in the idle state, after the previous one has been updated.
// Reset: arst_n clears the valid bits, occupancy, running time and control state at once;
// capacity returns to 16. Entry contents are not cleared; an entry is used only while valid.
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value store with least-frequently-used replacement over a scanned entry memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lfu_cache_table_assert.svh"

module lfu_cache_table (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire lfu_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output lfu_pkg::out_item_t              out_data,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lfu_pkg::CfgW-1:0]   cfg_data
);

	// One-hot controller: wait for a transaction, scan all slots, apply the update.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;

	// Architectural state kept in flip-flops.
	logic [lfu_pkg::Capacity-1:0] valid_q;
	logic [lfu_pkg::OccW-1:0]     occ_q;
	logic [31:0]                  time_q;
	logic [lfu_pkg::CfgW-1:0]     cap_q;

	// The operation being worked on.
	lfu_pkg::in_item_t            req_q;

	// Scan bookkeeping. Read address counter runs one past the last slot.
	logic [lfu_pkg::OccW-1:0]     rd_idx_q;
	logic                         cmp_vld_s1;
	logic [lfu_pkg::IdxW-1:0]     cmp_idx_s1;

	// Key match found during the scan.
	logic                         match_q;
	logic [lfu_pkg::IdxW-1:0]     match_idx_q;
	logic [31:0]                  match_val_q;
	logic [31:0]                  match_cnt_q;

	// Best eviction candidate so far: lowest count, then oldest stamp, then lowest slot.
	logic                         best_q;
	logic [lfu_pkg::IdxW-1:0]     best_idx_q;
	logic [31:0]                  best_cnt_q;
	logic [31:0]                  best_stamp_q;
	logic [31:0]                  best_key_q;

	// Memory interface.
	logic                         ram_we;
	logic [lfu_pkg::IdxW-1:0]     ram_waddr;
	lfu_pkg::entry_t              ram_wdata;
	logic                         ram_re;
	lfu_pkg::entry_t              ram_rdata;

	lfu_entry_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q[lfu_pkg::IdxW-1:0]),
		.rdata (ram_rdata)
	);

	// Configuration must be changed only while idle; the block does not enforce this. It is always accepted.
	assign cfg_ready = 1'b1;

	// A new transaction is taken only when the controller is idle. The output register
	// decouples the result side, so a waiting result does not block acceptance.
	assign in_ready = (state_q == ST_IDLE);

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	assign ram_re = (state_q == ST_SCAN) && !rd_idx_q[lfu_pkg::IdxW];

	// Compare stage: evaluate the entry that returned from memory this cycle.
	logic slot_v;
	logic key_eq;
	logic better;
	assign slot_v = cmp_vld_s1 && valid_q[cmp_idx_s1];
	assign key_eq = (ram_rdata.key == $unsigned(req_q.lookup_key));
	assign better = !best_q
		|| (ram_rdata.use_count < best_cnt_q)
		|| ((ram_rdata.use_count == best_cnt_q) && (ram_rdata.stamp < best_stamp_q));

	// Update stage decisions.
	logic [lfu_pkg::OccW-1:0]     limit;
	logic                         upd_go;
	logic                         is_put;
	logic                         put_on;
	logic                         do_evict;
	logic [lfu_pkg::Capacity-1:0] valid_after;
	logic                         free_found;
	logic [lfu_pkg::IdxW-1:0]     free_idx;
	logic                         do_insert;
	logic                         time_adv;

	assign limit = (cap_q > lfu_pkg::CfgW'(lfu_pkg::Capacity)) ?
		lfu_pkg::OccW'(lfu_pkg::Capacity) : lfu_pkg::OccW'(cap_q);
	assign upd_go   = (state_q == ST_UPDATE) && (!out_valid || out_ready);
	assign is_put   = (req_q.mode == lfu_pkg::MODE_PUT);
	assign put_on   = is_put && (limit != '0);
	assign do_evict = put_on && !match_q && (occ_q >= limit) && best_q;

	always_comb begin
		valid_after = valid_q;
		if (do_evict) begin
			valid_after[best_idx_q] = 1'b0;
		end
	end

	// Lowest free slot after any eviction.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = lfu_pkg::Capacity - 1; i >= 0; i--) begin
			if (!valid_after[i]) begin
				free_found = 1'b1;
				free_idx   = lfu_pkg::IdxW'(i);
			end
		end
	end

	assign do_insert = put_on && !match_q && free_found;
	assign time_adv  = is_put ? put_on : match_q;

	// Write back: refresh a hit entry, or fill a free slot with a new key.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = match_idx_q;
		ram_wdata = '{key: $unsigned(req_q.lookup_key), value: match_val_q,
			use_count: lfu_pkg::sat_inc(match_cnt_q), stamp: time_q};
		if (upd_go) begin
			if (match_q && (!is_put || put_on)) begin
				ram_we = 1'b1;
				if (is_put) begin
					ram_wdata.value = $unsigned(req_q.write_value);
				end
			end else if (do_insert) begin
				ram_we              = 1'b1;
				ram_waddr           = free_idx;
				ram_wdata.value     = $unsigned(req_q.write_value);
				ram_wdata.use_count = 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			occ_q      <= '0;
			time_q     <= '0;
			cap_q      <= lfu_pkg::CfgW'(lfu_pkg::Capacity);
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			match_q    <= 1'b0;
			best_q     <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q    <= ST_SCAN;
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						match_q    <= 1'b0;
						best_q     <= 1'b0;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= ram_re;
					if (ram_re) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (slot_v && key_eq && !match_q) begin
						match_q <= 1'b1;
					end
					if (slot_v && better) begin
						best_q <= 1'b1;
					end
					if (!ram_re && !cmp_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (upd_go) begin
						state_q   <= ST_IDLE;
						out_valid <= 1'b1;
						if (do_insert) begin
							valid_q                <= valid_after | (lfu_pkg::Capacity'(1) << free_idx);
							occ_q                  <= occ_q + 1'b1 - lfu_pkg::OccW'(do_evict);
						end else begin
							valid_q <= valid_after;
							occ_q   <= occ_q - lfu_pkg::OccW'(do_evict);
						end
						if (time_adv) begin
							time_q <= lfu_pkg::sat_inc(time_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= in_data;
		end
		cmp_idx_s1 <= rd_idx_q[lfu_pkg::IdxW-1:0];
		if (state_q == ST_SCAN && slot_v && key_eq && !match_q) begin
			match_idx_q <= cmp_idx_s1;
			match_val_q <= ram_rdata.value;
			match_cnt_q <= ram_rdata.use_count;
		end
		if (state_q == ST_SCAN && slot_v && better) begin
			best_idx_q   <= cmp_idx_s1;
			best_cnt_q   <= ram_rdata.use_count;
			best_stamp_q <= ram_rdata.stamp;
			best_key_q   <= ram_rdata.key;
		end
		if (upd_go) begin
			out_data.hit         <= match_q && (!is_put || put_on);
			out_data.read_value  <= (match_q && !is_put) ? $signed(match_val_q) : '0;
			out_data.evicted     <= do_evict;
			out_data.evicted_key <= do_evict ? $signed(best_key_q) : '0;
		end
	end

	// Occupancy tracks the valid bits and never exceeds the slot count.
	`LFU_ASSERT_NOW(a_occ_matches, 1'b1, $countones(valid_q) == occ_q, "occupancy mismatch")
	`LFU_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= lfu_pkg::OccW'(lfu_pkg::Capacity), "occ overflow")
	// An accepted transaction always starts a scan.
	`LFU_ASSERT_NEXT(a_start_scan, in_fire, state_q == ST_SCAN, "scan did not start")
	// A hit and an eviction never come from the same operation.
	`LFU_ASSERT_NOW(a_hit_evict, out_valid, !(out_data.hit && out_data.evicted), "hit with evict")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LFU cache table: a behavioral model of the store
// predicts every response, directed and random get/put traffic is driven with
// random gaps and back-pressure, and capacity is changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int QuietLimit = 20000;
	localparam int SettleCycles = 40;
	localparam int LongHold = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lfu_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	lfu_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [lfu_pkg::CfgW-1:0] cfg_data;

	lfu_cache_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Model of the store, kept separately from the RTL.
	logic        mdl_valid [lfu_pkg::Capacity];
	logic [31:0] mdl_key   [lfu_pkg::Capacity];
	logic [31:0] mdl_value [lfu_pkg::Capacity];
	logic [31:0] mdl_uses  [lfu_pkg::Capacity];
	logic [31:0] mdl_stamp [lfu_pkg::Capacity];
	logic [31:0] mdl_clock;
	int          mdl_fill;
	int          mdl_capacity;

	lfu_pkg::in_item_t  pending_ops[$];
	lfu_pkg::out_item_t expected_responses[$];
	int        errors;
	int        quiet_cycles;
	int        hold_off;
	int        long_hold_asks;
	int        long_hold_taken;
	int        gets_hit, puts_evicting, responses_seen;

	// Key pool: small so that hits and evictions are frequent.
	logic [31:0] key_pool[8];

	function automatic logic [31:0] bump(input logic [31:0] x);
		return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
	endfunction

	// Computes the response of one operation and updates the model.
	function automatic lfu_pkg::out_item_t predict_access(input lfu_pkg::in_item_t op);
		lfu_pkg::out_item_t r;
		int found, victim, free_slot, lim;
		r = '0;
		found = -1;
		victim = -1;
		free_slot = -1;
		lim = (mdl_capacity > lfu_pkg::Capacity) ? lfu_pkg::Capacity : mdl_capacity;
		for (int i = lfu_pkg::Capacity - 1; i >= 0; i--)
			if (mdl_valid[i] && mdl_key[i] == op.lookup_key) found = i;
		if (op.mode == lfu_pkg::MODE_GET) begin
			if (found < 0) return r;
			mdl_uses[found] = bump(mdl_uses[found]);
			mdl_stamp[found] = mdl_clock;
			mdl_clock = bump(mdl_clock);
			r.hit = 1'b1;
			r.read_value = mdl_value[found];
			gets_hit++;
			return r;
		end
		if (lim == 0) return r;
		if (found >= 0) begin
			mdl_value[found] = op.write_value;
			mdl_uses[found] = bump(mdl_uses[found]);
			mdl_stamp[found] = mdl_clock;
			r.hit = 1'b1;
		end else begin
			if (mdl_fill >= lim) begin
				for (int i = 0; i < lfu_pkg::Capacity; i++)
					if (mdl_valid[i] && (victim < 0 || mdl_uses[i] < mdl_uses[victim] ||
						(mdl_uses[i] == mdl_uses[victim] && mdl_stamp[i] < mdl_stamp[victim])))
						victim = i;
				if (victim >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = mdl_key[victim];
					mdl_valid[victim] = 1'b0;
					mdl_fill--;
					puts_evicting++;
				end
			end
			for (int i = lfu_pkg::Capacity - 1; i >= 0; i--)
				if (!mdl_valid[i]) free_slot = i;
			if (free_slot >= 0) begin
				mdl_valid[free_slot] = 1'b1;
				mdl_key[free_slot] = op.lookup_key;
				mdl_value[free_slot] = op.write_value;
				mdl_uses[free_slot] = 32'd1;
				mdl_stamp[free_slot] = mdl_clock;
				mdl_fill++;
			end
		end
		mdl_clock = bump(mdl_clock);
		return r;
	endfunction

	function automatic lfu_pkg::in_item_t random_op();
		lfu_pkg::in_item_t op;
		op.mode = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 8) op.lookup_key = key_pool[$urandom_range(0, 7)];
		else op.lookup_key = $urandom();
		op.write_value = $urandom();
		return op;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Acceptance is latched at the rising edge so the driver never reads a
	// handshake that is still settling.
	logic in_ready_seen;

	// Driver: presents queued operations, with random gaps between them.
	int send_gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready_seen) begin
			if (send_gap > 0 || pending_ops.size() == 0) begin
				in_valid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end else begin
				in_valid <= 1'b1;
				in_data <= pending_ops.pop_front();
				send_gap <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 60)) :
					($urandom_range(0, 1) ? 0 : int'($urandom_range(0, 3)));
			end
		end
	end

	always @(posedge clk) begin
		in_ready_seen <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_responses.push_back(predict_access(in_data));
	end

	// Receiver back-pressure; a long hold-off can be requested by the stimulus.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off <= 0;
			long_hold_taken <= long_hold_asks;
		end else if (long_hold_taken != long_hold_asks) begin
			out_ready <= 1'b0;
			hold_off <= LongHold;
			long_hold_taken <= long_hold_asks;
		end else if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if ($urandom_range(0, 19) == 0) begin
			out_ready <= 1'b0;
			hold_off <= int'($urandom_range(10, 80));
		end else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// Monitor: every response transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		lfu_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			responses_seen++;
			if (expected_responses.size() == 0) begin
				$error("response with no operation outstanding");
				errors++;
			end else begin
				want = expected_responses.pop_front();
				if (out_data.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, out_data.hit);
					errors++;
				end
				if (out_data.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value,
						out_data.read_value);
					errors++;
				end
				if (out_data.evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, out_data.evicted);
					errors++;
				end
				if (out_data.evicted_key !== want.evicted_key) begin
					$error("evicted_key: expected %0d, got %0d", want.evicted_key,
						out_data.evicted_key);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("watchdog expired with %0d responses outstanding",
				expected_responses.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	// Waits until every queued operation is accepted and answered.
	task automatic drain();
		while (pending_ops.size() != 0 || in_valid || expected_responses.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes the capacity register while the block is idle.
	task automatic set_capacity(input int cap);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap[lfu_pkg::CfgW-1:0];
		do @(posedge clk); while (!cfg_ready);
		mdl_capacity = cap;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Draws a fresh set of keys for the next random phase.
	task automatic new_pool();
		foreach (key_pool[i]) key_pool[i] = $urandom();
	endtask

	task automatic queue_op(input logic mode, input logic [31:0] k, input logic [31:0] v);
		lfu_pkg::in_item_t op;
		op.mode = mode;
		op.lookup_key = k;
		op.write_value = v;
		pending_ops.push_back(op);
	endtask

	// Queues random gets and puts; the store keeps whatever it holds across
	// capacity changes.
	task automatic random_phase(input int count);
		repeat (count) pending_ops.push_back(random_op());
	endtask

	initial begin
		errors = 0;
		quiet_cycles = 0;
		long_hold_asks = 0;
		gets_hit = 0;
		puts_evicting = 0;
		responses_seen = 0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		foreach (mdl_valid[i]) mdl_valid[i] = 1'b0;
		mdl_clock = '0;
		mdl_fill = 0;
		mdl_capacity = 16;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at capacity two: misses, extreme keys and values, updates,
		// eviction by count, and a get miss that must not move time.
		set_capacity(2);
		queue_op(lfu_pkg::MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_op(lfu_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_op(lfu_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_op(lfu_pkg::MODE_GET, 32'h8000_0000, 32'h0);
		queue_op(lfu_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0);
		queue_op(lfu_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_op(lfu_pkg::MODE_PUT, 32'h0, 32'h0);
		queue_op(lfu_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
		queue_op(lfu_pkg::MODE_GET, 32'h1, 32'h0);
		queue_op(lfu_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
		queue_op(lfu_pkg::MODE_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_op(lfu_pkg::MODE_GET, 32'h5555_5555, 32'h0);
		// The sender pauses here until every response has come back.
		drain();
		// Zero capacity ignores puts; gets of existing keys still hit.
		set_capacity(0);
		queue_op(lfu_pkg::MODE_PUT, 32'h0BAD_F00D, 32'h1);
		queue_op(lfu_pkg::MODE_GET, 32'h0BAD_F00D, 32'h0);
		queue_op(lfu_pkg::MODE_GET, 32'h5555_5555, 32'h0);
		drain();
		// Capacity above the table size is clamped.
		set_capacity(31);
		for (int i = 0; i < 18; i++) queue_op(lfu_pkg::MODE_PUT, i, ~i);
		// Long receiver hold-off while the sender keeps offering items.
		long_hold_asks++;
		drain();

		// Random phases over several capacities, extremes included.
		begin
			int caps[7];
			caps = '{16, 1, 5, 31, 0, 3, 16};
			foreach (caps[p]) begin
				set_capacity(caps[p]);
				new_pool();
				random_phase(175);
				drain();
			end
		end

		$display("covered %0d responses, %0d get hits, %0d evicting puts",
			responses_seen, gets_hit, puts_evicting);
		$display("capacities 0, 1, 2, 3, 5, 16 and clamped 31 were exercised");
		if (errors == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/lfu_pkg.sv
rtl/core/lfu_entry_ram.sv
rtl/core/lfu_cache_table.sv
bench/tb.sv
